@@ design/vad_hangover_state_machine_macros.svh @@
// Assertion macros shared by the voice activity hangover design.
// No dependencies; included by the modules that carry assertions.
`ifndef VAD_HANGOVER_STATE_MACHINE_MACROS_SVH
`define VAD_HANGOVER_STATE_MACHINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VHSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vhsm: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define VHSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vhsm: next-cycle implication failed");

`endif

@@ design/vhsm_pkg.sv @@
// Shared types and constants of the voice activity hangover block.
// No dependencies; imported by every module of the block but vhsm_fifo.
package vhsm_pkg;

   // Field widths.
   localparam int PROB_W     = 16;
   localparam int THR_W      = 17;
   localparam int RUN_W      = 16;
   localparam int FRAME_W    = 31;
   localparam int POS_W      = 32;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   // Saturation limits.
   localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
   localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SILENCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEECH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEECH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_START   = 3'd4;

   typedef enum logic [1:0] {
      ST_SILENCE         = 2'd0,
      ST_POSSIBLE_SPEECH = 2'd1,
      ST_SPEECH          = 2'd2,
      ST_POSSIBLE_SILENCE = 2'd3
   } vad_state_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [15:0]      min_silence_frames;
      logic [7:0]       min_speech_frames;
      logic [15:0]      max_speech_frames;
      logic [7:0]       pad_start_frames;
   } cfg_type;

   // Classified frame handed from the front to the back.
   typedef struct packed {
      logic               voiced;
      logic [FRAME_W-1:0] frame_index;
   } mid_item_type;

   // Result item waiting in the output queue.
   typedef struct packed {
      logic               active;
      vad_state_type      vad_state;
      logic [POS_W-1:0]   speech_start;
      logic [POS_W-1:0]   speech_end;
      logic [FRAME_W-1:0] frame_index;
   } rsp_item_type;

endpackage

@@ design/vhsm_fifo.sv @@
// Small register-based queue with push/full and pop/empty sides.
// Depends on nothing but its parameters.
module vhsm_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/vhsm_front.sv @@
// Front end: accepts frames, keeps the probability window and frame count,
// and classifies each frame as speech or not. Depends on vhsm_pkg.
`include "vad_hangover_state_machine_macros.svh"

module vhsm_front #(
   parameter int WINDOW_LEN = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [vhsm_pkg::PROB_W-1:0]  req_prob,
   input  logic [vhsm_pkg::THR_W-1:0]   threshold,
   output logic                         mid_push,
   output vhsm_pkg::mid_item_type       mid_item,
   input  logic                         mid_full
);
   import vhsm_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = PROB_W + FILL_W;
   localparam int PROD_W = THR_W + FILL_W;

   logic [PROB_W-1:0]  win_ff [WINDOW_LEN];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PROD_W-1:0]  limit;
   logic               accept;
   logic               window_full;

   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   // Running sum: drop the oldest entry once the window is full.
   always_comb begin
      window_full = (fill_ff == FILL_W'(WINDOW_LEN));
      fill_in     = window_full ? fill_ff : fill_ff + FILL_W'(1);
      sum_in      = sum_ff + SUM_W'(req_prob);
      if (window_full) begin
         sum_in = sum_in - SUM_W'(win_ff[WINDOW_LEN-1]);
      end
      frame_in = (frame_ff == FRAME_MAX) ? frame_ff : frame_ff + FRAME_W'(1);
      limit    = PROD_W'(threshold) * PROD_W'(fill_in);
   end

   // The comparison against threshold times count replaces the average.
   assign mid_push              = accept;
   assign mid_item.voiced       = (PROD_W'(sum_in) >= limit);
   assign mid_item.frame_index  = frame_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         fill_ff  <= '0;
         frame_ff <= '0;
      end else if (accept) begin
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         frame_ff <= frame_in;
      end
   end

   // Shift line of recent probabilities; entries are read only once filled.
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= req_prob;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   `VHSM_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(WINDOW_LEN))
   `VHSM_ASSERT_IMPLY(a_empty_sum, clock, reset, fill_ff == '0, sum_ff == '0)
   `VHSM_ASSERT_NEXT(a_frame_counts, clock, reset, accept, frame_ff != '0)

endmodule

@@ design/vhsm_back.sv @@
// Back end: runs the hangover state machine on classified frames and
// builds the result items. Depends on vhsm_pkg.
`include "vad_hangover_state_machine_macros.svh"

module vhsm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  vhsm_pkg::cfg_type        cfg,
   input  vhsm_pkg::mid_item_type   mid_item,
   input  logic                     mid_empty,
   output logic                     mid_pop,
   output logic                     out_push,
   output vhsm_pkg::rsp_item_type   out_item,
   input  logic                     out_full
);
   import vhsm_pkg::*;

   vad_state_type      state_ff, state_in;
   logic [RUN_W-1:0]   speech_run_ff, speech_run_in;
   logic [RUN_W-1:0]   silence_run_ff, silence_run_in;
   logic               split_ff, split_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [POS_W-1:0]   end_ff, end_in;
   logic [RUN_W-1:0]   speech_inc, silence_inc;
   logic [FRAME_W-1:0] fc;
   logic signed [33:0] start_raw, end_next, start_lo, start_mid, start_hi;
   logic               fire;

   assign fire     = !mid_empty && !out_full;
   assign mid_pop  = fire;
   assign out_push = fire;
   assign fc       = mid_item.frame_index;

   // Saturating run increments and the padded, clamped start frame.
   always_comb begin
      speech_inc  = (speech_run_ff == RUN_MAX) ? speech_run_ff : speech_run_ff + RUN_W'(1);
      silence_inc = (silence_run_ff == RUN_MAX) ? silence_run_ff : silence_run_ff + RUN_W'(1);
      start_raw   = $signed({3'b000, fc}) + 34'sd1 - $signed({18'd0, speech_inc})
                    - $signed({26'd0, cfg.pad_start_frames});
      end_next    = $signed({{2{end_ff[POS_W-1]}}, end_ff}) + 34'sd1;
      start_lo    = (start_raw < 34'sd1) ? 34'sd1 : start_raw;
      start_mid   = (start_lo < end_next) ? end_next : start_lo;
      start_hi    = (start_mid > 34'sd2147483647) ? 34'sd2147483647 : start_mid;
   end

   // Next state of the hangover machine.
   always_comb begin
      state_in       = state_ff;
      speech_run_in  = speech_run_ff;
      silence_run_in = silence_run_ff;
      split_in       = 1'b0;
      end_in         = end_ff;
      start_in       = split_ff ? {1'b0, fc} : start_ff;
      unique case (state_ff)
         ST_SILENCE: begin
            if (mid_item.voiced) begin
               state_in      = ST_POSSIBLE_SPEECH;
               speech_run_in = speech_inc;
            end else begin
               silence_run_in = silence_inc;
               speech_run_in  = '0;
            end
         end
         ST_POSSIBLE_SPEECH: begin
            if (mid_item.voiced) begin
               speech_run_in = speech_inc;
               if (speech_inc >= {8'd0, cfg.min_speech_frames}) begin
                  state_in       = ST_SPEECH;
                  start_in       = start_hi[POS_W-1:0];
                  silence_run_in = '0;
               end
            end else begin
               state_in       = ST_SILENCE;
               silence_run_in = RUN_W'(1);
               speech_run_in  = '0;
            end
         end
         ST_SPEECH: begin
            speech_run_in = speech_inc;
            if (mid_item.voiced) begin
               silence_run_in = '0;
               if (speech_inc >= cfg.max_speech_frames) begin
                  split_in      = 1'b1;
                  speech_run_in = '0;
                  end_in        = {1'b0, fc};
                  start_in      = '1;
               end
            end else begin
               state_in       = ST_POSSIBLE_SILENCE;
               silence_run_in = silence_inc;
            end
         end
         ST_POSSIBLE_SILENCE: begin
            speech_run_in = speech_inc;
            if (mid_item.voiced) begin
               state_in       = ST_SPEECH;
               silence_run_in = '0;
               if (speech_inc >= cfg.max_speech_frames) begin
                  split_in      = 1'b1;
                  speech_run_in = '0;
                  end_in        = {1'b0, fc};
                  start_in      = '1;
               end
            end else begin
               silence_run_in = silence_inc;
               if (silence_inc >= cfg.min_silence_frames) begin
                  state_in      = ST_SILENCE;
                  end_in        = {1'b0, fc};
                  start_in      = '1;
                  speech_run_in = '0;
               end
            end
         end
      endcase
   end

   // Result item reflects the state after this frame.
   assign out_item.active       = (state_in == ST_SPEECH) || (state_in == ST_POSSIBLE_SILENCE);
   assign out_item.vad_state    = state_in;
   assign out_item.speech_start = start_in;
   assign out_item.speech_end   = end_in;
   assign out_item.frame_index  = fc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SILENCE;
         speech_run_ff  <= '0;
         silence_run_ff <= '0;
         split_ff       <= 1'b0;
         start_ff       <= '1;
         end_ff         <= '1;
      end else if (fire) begin
         state_ff       <= state_in;
         speech_run_ff  <= speech_run_in;
         silence_run_ff <= silence_run_in;
         split_ff       <= split_in;
         start_ff       <= start_in;
         end_ff         <= end_in;
      end
   end

   `VHSM_ASSERT_IMPLY(a_split_in_speech, clock, reset, split_ff, state_ff == ST_SPEECH)
   `VHSM_ASSERT_IMPLY(a_split_no_start, clock, reset, split_ff, start_ff == '1)
   `VHSM_ASSERT_IMPLY(a_idle_no_start, clock, reset,
      (state_ff == ST_SILENCE) || (state_ff == ST_POSSIBLE_SPEECH), start_ff == '1)

endmodule

@@ design/vad_hangover_state_machine.sv @@
// Voice activity hangover post-processor: accepts one speech probability per
// cycle while req_full is low and returns one result item per frame. The
// front end classifies an item in the cycle it is accepted (window sum and
// threshold compare) and writes it into a two-entry queue; the back end
// takes it from that queue, updates the state machine and writes the result
// into a two-entry output queue, which presents it on the rsp_ ports.
// Neither end has a busy state, so the sustained rate is one item per clock
// while neither queue fills. While rsp_pop stays low, four items wait inside
// before req_full rises. There is no clearing pass after reset.
// Depends on vhsm_pkg, vhsm_fifo, vhsm_front and vhsm_back.
module vad_hangover_state_machine #(
   parameter int WINDOW_LEN = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [vhsm_pkg::PROB_W-1:0]      req_prob,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_active,
   output logic [1:0]                       rsp_vad_state,
   output logic signed [vhsm_pkg::POS_W-1:0] rsp_speech_start,
   output logic signed [vhsm_pkg::POS_W-1:0] rsp_speech_end,
   output logic [vhsm_pkg::FRAME_W-1:0]     rsp_frame_index,
   input  logic                             csr_write,
   input  logic [vhsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vhsm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vhsm_pkg::*;

   localparam int MID_W = $bits(mid_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   cfg_type      cfg_ff, cfg_in;
   mid_item_type front_item, back_item;
   rsp_item_type back_rsp, queue_rsp;
   logic         mid_push, mid_full, mid_pop, mid_empty;
   logic         out_push, out_full;

   // Configuration register decode; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD:   cfg_in.threshold          = csr_wdata;
            CSR_MIN_SILENCE: cfg_in.min_silence_frames = csr_wdata[15:0];
            CSR_MIN_SPEECH:  cfg_in.min_speech_frames  = csr_wdata[7:0];
            CSR_MAX_SPEECH:  cfg_in.max_speech_frames  = csr_wdata[15:0];
            CSR_PAD_START:   cfg_in.pad_start_frames   = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold          <= THR_W'(32768);
         cfg_ff.min_silence_frames <= 16'd30;
         cfg_ff.min_speech_frames  <= 8'd8;
         cfg_ff.max_speech_frames  <= 16'd2000;
         cfg_ff.pad_start_frames   <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end classifies frames.
   vhsm_front #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_prob  (req_prob),
      .threshold (cfg_ff.threshold),
      .mid_push  (mid_push),
      .mid_item  (front_item),
      .mid_full  (mid_full)
   );

   // Queue between the two ends.
   vhsm_fifo #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (front_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (back_item),
      .empty (mid_empty)
   );

   // Back end runs the state machine.
   vhsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_item  (back_item),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .out_push  (out_push),
      .out_item  (back_rsp),
      .out_full  (out_full)
   );

   // Output queue holds finished items until they are popped.
   vhsm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (queue_rsp),
      .empty (rsp_empty)
   );

   assign rsp_active       = queue_rsp.active;
   assign rsp_vad_state    = queue_rsp.vad_state;
   assign rsp_speech_start = $signed(queue_rsp.speech_start);
   assign rsp_speech_end   = $signed(queue_rsp.speech_end);
   assign rsp_frame_index  = queue_rsp.frame_index;

endmodule
